// ----- hdl/pl0ts_pkg.sv -----
// pl0ts_pkg: token codes, character constants, reserved word table and the
// token record shared by the scanner top level, keyword matcher and result queue.
// No dependencies.
package pl0ts_pkg;

    localparam int SYM_W      = 6;
    localparam int VALUE_W    = 47;
    localparam int HEAD_W     = 64;
    localparam int TAIL_W     = 16;
    localparam int LEN_W      = 4;
    localparam int NAME_BYTES = 10;
    localparam int NAME_W     = NAME_BYTES * 8;
    localparam int KW_COUNT   = 14;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    // token codes
    localparam logic [SYM_W-1:0] SY_NUL     = 6'd12;
    localparam logic [SYM_W-1:0] SY_IDENT   = 6'd13;
    localparam logic [SYM_W-1:0] SY_NUMBER  = 6'd14;
    localparam logic [SYM_W-1:0] SY_PLUS    = 6'd15;
    localparam logic [SYM_W-1:0] SY_MINUS   = 6'd16;
    localparam logic [SYM_W-1:0] SY_TIMES   = 6'd17;
    localparam logic [SYM_W-1:0] SY_SLASH   = 6'd18;
    localparam logic [SYM_W-1:0] SY_EQL     = 6'd19;
    localparam logic [SYM_W-1:0] SY_NEQ     = 6'd20;
    localparam logic [SYM_W-1:0] SY_LSS     = 6'd21;
    localparam logic [SYM_W-1:0] SY_LEQ     = 6'd22;
    localparam logic [SYM_W-1:0] SY_GTR     = 6'd23;
    localparam logic [SYM_W-1:0] SY_GEQ     = 6'd24;
    localparam logic [SYM_W-1:0] SY_LPAREN  = 6'd25;
    localparam logic [SYM_W-1:0] SY_RPAREN  = 6'd26;
    localparam logic [SYM_W-1:0] SY_COMMA   = 6'd27;
    localparam logic [SYM_W-1:0] SY_SEMI    = 6'd28;
    localparam logic [SYM_W-1:0] SY_COLON   = 6'd29;
    localparam logic [SYM_W-1:0] SY_PERIOD  = 6'd30;
    localparam logic [SYM_W-1:0] SY_BECOMES = 6'd31;
    localparam logic [SYM_W-1:0] SY_TOOBIG  = 6'd34;

    // character constants
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    // reserved words, left aligned, zero padded to ten characters
    localparam logic [NAME_W-1:0] KW_TEXT [KW_COUNT] = '{
        {"BEGIN", 40'd0}, {"CALL", 48'd0}, {"CONST", 40'd0}, {"DO", 64'd0},
        {"END", 56'd0}, {"IF", 64'd0}, {"ELSE", 48'd0}, {"ODD", 56'd0},
        {"PROCEDURE", 8'd0}, {"THEN", 48'd0}, {"VAR", 56'd0}, {"WHILE", 40'd0},
        {"REPEAT", 32'd0}, {"UNTIL", 40'd0}
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd4, 4'd5, 4'd2, 4'd3, 4'd2, 4'd4, 4'd3, 4'd9, 4'd4, 4'd3, 4'd5,
        4'd6, 4'd5
    };
    localparam logic [SYM_W-1:0] KW_CODE [KW_COUNT] = '{
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10,
        6'd11, 6'd32, 6'd33
    };

    typedef struct packed {
        logic [SYM_W-1:0]   symbol;
        logic [VALUE_W-1:0] number_value;
        logic [HEAD_W-1:0]  ident_head;
        logic [TAIL_W-1:0]  ident_tail;
        logic [LEN_W-1:0]   ident_length;
        logic               last_of_run;
    } tok_t;

    function automatic tok_t mk_tok(input logic [SYM_W-1:0] sym);
        tok_t t;
        t = '0;
        t.symbol = sym;
        return t;
    endfunction

    function automatic logic [SYM_W-1:0] single_char(input logic [7:0] c);
        logic [SYM_W-1:0] s;
        unique case (c)
            CH_PLUS:   s = SY_PLUS;
            CH_MINUS:  s = SY_MINUS;
            CH_STAR:   s = SY_TIMES;
            CH_SLASH:  s = SY_SLASH;
            CH_EQUAL:  s = SY_EQL;
            CH_HASH:   s = SY_NEQ;
            CH_QUOTE:  s = SY_LEQ;
            CH_AT:     s = SY_GEQ;
            CH_LPAREN: s = SY_LPAREN;
            CH_RPAREN: s = SY_RPAREN;
            CH_COMMA:  s = SY_COMMA;
            CH_SEMI:   s = SY_SEMI;
            CH_PERIOD: s = SY_PERIOD;
            default:   s = SY_NUL;
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/pl0ts_kw_match.sv -----
// pl0ts_kw_match: parallel exact compare of the held name against the
// fourteen reserved words. Depends on pl0ts_pkg.
module pl0ts_kw_match
    import pl0ts_pkg::*;
(
    input  logic [NAME_W-1:0] name_text,
    input  logic [LEN_W-1:0]  name_len,
    output logic              kw_hit,
    output logic [SYM_W-1:0]  kw_code
);

    logic [KW_COUNT-1:0] hits;

    // unused name bytes are zero, so a full-width compare equals a prefix compare
    genvar k;
    generate
        for (k = 0; k < KW_COUNT; k++) begin : g_kw
            assign hits[k] = (name_len == KW_LEN[k]) && (name_text == KW_TEXT[k]);
        end
    endgenerate

    always_comb begin
        kw_code = '0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (hits[i]) begin
                kw_code = kw_code | KW_CODE[i];
            end
        end
    end

    assign kw_hit = |hits;

endmodule

// ----- hdl/pl0ts_tok_queue.sv -----
// pl0ts_tok_queue: four-entry token queue, up to two words pushed and one
// popped per cycle. Depends on pl0ts_pkg.
module pl0ts_tok_queue
    import pl0ts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_n,
    input  tok_t       push0,
    input  tok_t       push1,
    output logic       has_room,
    output logic       out_valid,
    input  logic       out_ready,
    output tok_t       out_tok
);

    tok_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;
    logic [QPTR_W-1:0] wr_ptr_plus1;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_tok      = mem_reg[rd_ptr_reg];
    assign has_room     = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("token queue overfilled");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != QCNT_W'(QUEUE_DEPTH)) |-> (QCNT_W'(QPTR_W'(wr_ptr_reg - rd_ptr_reg)) == count_reg))
        else $error("queue pointers disagree with fill count");

    a_push_pair_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n == 2'd2) |-> $past(has_room) || has_room || (count_reg <= QCNT_W'(QUEUE_DEPTH - 2)))
        else $error("two words pushed without room");

endmodule

// ----- hdl/pl0_token_scanner.sv -----
// pl0_token_scanner: PL/0 lexical scanner, one source byte per word in, one
// token per word out. Depends on pl0ts_pkg, pl0ts_kw_match, pl0ts_tok_queue.
//
//  channel | dir | tdata                         | tuser       | tlast
//  s_      | in  | source_char                   | action      | -
//  m_      | out | symbol,value,head,tail,length | -           | last_of_run
//
// one input word is taken per cycle while the four-entry token queue has two
// free slots; its tokens enter the queue at that same edge.
// a token is written into the queue when its word is accepted and is offered on m_ behind any tokens already queued.
// words that produce two tokens need two output transfers, so the output port sets
// the sustained rate when pairs are frequent.
// reset clears the scan state to idle and empties the queue.
module pl0_token_scanner
    import pl0ts_pkg::*;
#(
    parameter int MAX_NAME_CHARS = 10,
    parameter int MAX_DIGITS     = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] source_char
    input  logic         s_tuser,   // [0] action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // [5:0] symbol, [52:6] number_value,
                                    // [116:53] ident_head, [132:117] ident_tail,
                                    // [136:133] ident_length, rest zero
    output logic         m_tlast    // last_of_run
);

    localparam int NC_W = $clog2(MAX_NAME_CHARS + 1);
    localparam int DC_W = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_NAME    = 3'd1;
    localparam logic [2:0] MODE_NUM     = 3'd2;
    localparam logic [2:0] MODE_COLON   = 3'd3;
    localparam logic [2:0] MODE_LESS    = 3'd4;
    localparam logic [2:0] MODE_GREATER = 3'd5;

    logic [2:0]         mode_reg, mode_next;
    logic [7:0]         name_buf_reg [MAX_NAME_CHARS];
    logic [7:0]         name_buf_next [MAX_NAME_CHARS];
    logic [NC_W-1:0]    name_count_reg, name_count_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [DC_W-1:0]    digit_count_reg, digit_count_next;
    logic               too_long_reg, too_long_next;

    logic               s_accept;
    logic [7:0]         c;
    logic               is_up, is_dig, is_space;
    logic [NAME_W-1:0]  name_text;
    logic               kw_hit;
    logic [SYM_W-1:0]   kw_code;
    logic               pending_valid;
    tok_t               pending_tok;
    logic               pair_hit;
    logic [SYM_W-1:0]   pair_sym;
    logic [VALUE_W-1:0] value_x10;
    logic               emit_a, emit_b;
    tok_t               tok_a, tok_b;
    tok_t               push0, push1;
    logic [1:0]         push_n;
    logic               has_room;
    tok_t               out_tok;

    assign s_tready = has_room;
    assign s_accept = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign is_up    = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    assign is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_space = (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF);

    // held name as ten bytes, first character on top
    genvar g;
    generate
        for (g = 0; g < NAME_BYTES; g++) begin : g_name
            if (g < MAX_NAME_CHARS) begin : g_used
                assign name_text[NAME_W-1-8*g -: 8] = name_buf_reg[g];
            end else begin : g_pad
                assign name_text[NAME_W-1-8*g -: 8] = 8'd0;
            end
        end
    endgenerate

    pl0ts_kw_match u_kw (
        .name_text (name_text),
        .name_len  (LEN_W'(name_count_reg)),
        .kw_hit    (kw_hit),
        .kw_code   (kw_code)
    );

    // token that the current mode would flush
    always_comb begin
        pending_valid = 1'b1;
        pending_tok   = mk_tok(SY_NUL);
        unique case (mode_reg)
            MODE_NAME: begin
                if (kw_hit) begin
                    pending_tok = mk_tok(kw_code);
                end else begin
                    pending_tok              = mk_tok(SY_IDENT);
                    pending_tok.ident_head   = name_text[NAME_W-1 -: HEAD_W];
                    pending_tok.ident_tail   = name_text[TAIL_W-1:0];
                    pending_tok.ident_length = LEN_W'(name_count_reg);
                end
            end
            MODE_NUM: begin
                if (too_long_reg) begin
                    pending_tok = mk_tok(SY_TOOBIG);
                end else begin
                    pending_tok              = mk_tok(SY_NUMBER);
                    pending_tok.number_value = value_reg;
                end
            end
            MODE_COLON:   pending_tok = mk_tok(SY_COLON);
            MODE_LESS:    pending_tok = mk_tok(SY_LSS);
            MODE_GREATER: pending_tok = mk_tok(SY_GTR);
            default:      pending_valid = 1'b0;
        endcase
    end

    // second character of a two-character operator
    always_comb begin
        pair_hit = 1'b0;
        pair_sym = SY_BECOMES;
        unique case (mode_reg)
            MODE_COLON: begin
                pair_hit = (c == CH_EQUAL);
            end
            MODE_LESS: begin
                pair_hit = (c == CH_EQUAL) || (c == CH_GREATER);
                pair_sym = (c == CH_EQUAL) ? SY_LEQ : SY_NEQ;
            end
            MODE_GREATER: begin
                pair_hit = (c == CH_EQUAL);
                pair_sym = SY_GEQ;
            end
            default: pair_hit = 1'b0;
        endcase
    end

    assign value_x10 = {value_reg[VALUE_W-4:0], 3'b000} + {value_reg[VALUE_W-2:0], 1'b0};

    always_comb begin
        mode_next        = mode_reg;
        name_buf_next    = name_buf_reg;
        name_count_next  = name_count_reg;
        value_next       = value_reg;
        digit_count_next = digit_count_reg;
        too_long_next    = too_long_reg;
        emit_a           = 1'b0;
        emit_b           = 1'b0;
        tok_a            = pending_tok;
        tok_b            = mk_tok(single_char(c));
        if (s_accept) begin
            if (s_tuser) begin
                emit_a    = pending_valid;
                mode_next = MODE_IDLE;
            end else if (c != CH_TAB) begin
                priority if (mode_reg == MODE_NAME && (is_up || is_dig)) begin
                    for (int i = 0; i < MAX_NAME_CHARS; i++) begin
                        if (name_count_reg == NC_W'(i)) begin
                            name_buf_next[i] = c;
                        end
                    end
                    if (name_count_reg < NC_W'(MAX_NAME_CHARS)) begin
                        name_count_next = name_count_reg + NC_W'(1);
                    end
                end else if (mode_reg == MODE_NUM && is_dig) begin
                    if (digit_count_reg >= DC_W'(MAX_DIGITS)) begin
                        too_long_next = 1'b1;
                    end else begin
                        value_next       = value_x10 + VALUE_W'(c[3:0]);
                        digit_count_next = digit_count_reg + DC_W'(1);
                    end
                end else if (pair_hit) begin
                    emit_a    = 1'b1;
                    tok_a     = mk_tok(pair_sym);
                    mode_next = MODE_IDLE;
                end else begin
                    emit_a    = pending_valid;
                    mode_next = MODE_IDLE;
                    priority if (is_space) begin
                        mode_next = MODE_IDLE;
                    end else if (is_up) begin
                        for (int i = 0; i < MAX_NAME_CHARS; i++) begin
                            name_buf_next[i] = (i == 0) ? c : 8'd0;
                        end
                        name_count_next = NC_W'(1);
                        mode_next       = MODE_NAME;
                    end else if (is_dig) begin
                        value_next       = VALUE_W'(c[3:0]);
                        digit_count_next = DC_W'(1);
                        too_long_next    = 1'b0;
                        mode_next        = MODE_NUM;
                    end else if (c == CH_COLON) begin
                        mode_next = MODE_COLON;
                    end else if (c == CH_LESS) begin
                        mode_next = MODE_LESS;
                    end else if (c == CH_GREATER) begin
                        mode_next = MODE_GREATER;
                    end else begin
                        emit_b = 1'b1;
                    end
                end
            end
        end
    end

    // order the tokens of this word and mark the final one
    always_comb begin
        push0             = emit_a ? tok_a : tok_b;
        push0.last_of_run = !(emit_a && emit_b);
        push1             = tok_b;
        push1.last_of_run = 1'b1;
        push_n            = 2'(emit_a) + 2'(emit_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            name_count_reg  <= '0;
            value_reg       <= '0;
            digit_count_reg <= '0;
            too_long_reg    <= 1'b0;
            for (int i = 0; i < MAX_NAME_CHARS; i++) begin
                name_buf_reg[i] <= 8'd0;
            end
        end else begin
            mode_reg        <= mode_next;
            name_count_reg  <= name_count_next;
            value_reg       <= value_next;
            digit_count_reg <= digit_count_next;
            too_long_reg    <= too_long_next;
            name_buf_reg    <= name_buf_next;
        end
    end

    pl0ts_tok_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push0     (push0),
        .push1     (push1),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    assign m_tdata = {7'd0, out_tok.ident_length, out_tok.ident_tail, out_tok.ident_head,
                      out_tok.number_value, out_tok.symbol};
    assign m_tlast = out_tok.last_of_run;

    a_name_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_NAME) |->
            (name_count_reg != '0) && (name_count_reg <= NC_W'(MAX_NAME_CHARS)))
        else $error("name mode with bad character count");

    a_digit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_NUM) |->
            (digit_count_reg != '0) && (digit_count_reg <= DC_W'(MAX_DIGITS)))
        else $error("number mode with bad digit count");

    a_no_push_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |-> (push_n == 2'd0))
        else $error("token pushed without an accepted word");

    a_symbol_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] <= SY_TOOBIG))
        else $error("symbol code out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

// ----- test/pl0_token_scanner_tb.sv -----
`timescale 1ns / 1ps
// pl0_token_scanner_tb: self-checking bench for the pl0 token scanner. Feeds
// character words, predicts the token stream and checks each token word in order.
// Depends on pl0ts_pkg and the pl0_token_scanner rtl.
module pl0_token_scanner_tb;
    import pl0ts_pkg::*;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam int NAME_KEEP    = 10;
    localparam int DIGIT_KEEP   = 14;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [7:0] PUNCT_CHARS [13] = '{
        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL, CH_HASH, CH_QUOTE, CH_AT,
        CH_LPAREN, CH_RPAREN, CH_COMMA, CH_SEMI, CH_PERIOD
    };
    localparam logic [7:0] SEP_CHARS [4] = '{CH_SPACE, CH_CR, CH_LF, CH_TAB};

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_NAME, SCAN_NUM, SCAN_COLON, SCAN_LESS, SCAN_GREATER
    } scan_mode_e;

    typedef struct {
        logic       action;
        logic [7:0] ch;
        bit         hold;
    } src_word_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;     // [7:0] source_char
    logic         s_tuser  = ACT_CHAR;  // [0] action
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;              // [5:0] symbol, [52:6] number_value,
                                        // [116:53] ident_head, [132:117] ident_tail,
                                        // [136:133] ident_length, rest zero
    logic         m_tlast;              // last_of_run

    // scanner state as predicted
    scan_mode_e         scan_mode = SCAN_IDLE;
    logic [7:0]         name_chars [NAME_BYTES] = '{default: 8'h00};
    int                 name_len = 0;
    logic [VALUE_W-1:0] num_value = '0;
    int                 num_digits = 0;
    bit                 num_too_long = 1'b0;

    tok_t      run_toks [$];
    tok_t      tok_expected [$];
    src_word_t src_words [$];
    int        words_queued = 0;
    int        err_count = 0;
    int        send_idle = 0;
    int        recv_idle = 0;
    logic      word_taken = 1'b0;
    int        idle_cycles = 0;

    pl0_token_scanner u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_upper(input logic [7:0] c);
        return c >= CH_UPPER_A && c <= CH_UPPER_Z;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [SYM_W-1:0] punct_symbol(input logic [7:0] c);
        case (c)
            CH_PLUS:   return SY_PLUS;
            CH_MINUS:  return SY_MINUS;
            CH_STAR:   return SY_TIMES;
            CH_SLASH:  return SY_SLASH;
            CH_EQUAL:  return SY_EQL;
            CH_HASH:   return SY_NEQ;
            CH_QUOTE:  return SY_LEQ;
            CH_AT:     return SY_GEQ;
            CH_LPAREN: return SY_LPAREN;
            CH_RPAREN: return SY_RPAREN;
            CH_COMMA:  return SY_COMMA;
            CH_SEMI:   return SY_SEMI;
            CH_PERIOD: return SY_PERIOD;
            default:   return SY_NUL;
        endcase
    endfunction

    task automatic add_token(input logic [SYM_W-1:0] sym, input logic [VALUE_W-1:0] value,
                             input logic [HEAD_W-1:0] head, input logic [TAIL_W-1:0] tail,
                             input logic [LEN_W-1:0] len);
        tok_t t;
        t = '0;
        t.symbol       = sym;
        t.number_value = value;
        t.ident_head   = head;
        t.ident_tail   = tail;
        t.ident_length = len;
        run_toks.push_back(t);
    endtask

    // reserved words win over identifiers on an exact match of the kept text
    task automatic flush_name();
        logic [NAME_W-1:0] text;
        logic [SYM_W-1:0]  sym;
        text = '0;
        for (int i = 0; i < NAME_BYTES; i++) text[NAME_W-1-8*i -: 8] = name_chars[i];
        sym = SY_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (KW_LEN[k] == name_len && KW_TEXT[k] == text) sym = KW_CODE[k];
        end
        if (sym == SY_IDENT) begin
            add_token(SY_IDENT, '0, text[NAME_W-1 -: HEAD_W], text[TAIL_W-1:0],
                      LEN_W'(name_len));
        end else begin
            add_token(sym, '0, '0, '0, '0);
        end
    endtask

    task automatic flush_pending();
        case (scan_mode)
            SCAN_NAME: flush_name();
            SCAN_NUM: begin
                if (num_too_long) add_token(SY_TOOBIG, '0, '0, '0, '0);
                else add_token(SY_NUMBER, num_value, '0, '0, '0);
            end
            SCAN_COLON:   add_token(SY_COLON, '0, '0, '0, '0);
            SCAN_LESS:    add_token(SY_LSS, '0, '0, '0, '0);
            SCAN_GREATER: add_token(SY_GTR, '0, '0, '0, '0);
            default: ;
        endcase
        scan_mode = SCAN_IDLE;
    endtask

    task automatic add_digit(input logic [7:0] c);
        if (num_digits >= DIGIT_KEEP) begin
            num_too_long = 1'b1;
        end else begin
            num_value = num_value * 10 + VALUE_W'(c - CH_ZERO);
            num_digits++;
        end
    endtask

    task automatic start_token(input logic [7:0] c);
        if (c == CH_SPACE || c == CH_CR || c == CH_LF) return;
        if (is_upper(c)) begin
            foreach (name_chars[i]) name_chars[i] = 8'h00;
            name_chars[0] = c;
            name_len = 1;
            scan_mode = SCAN_NAME;
        end else if (is_digit(c)) begin
            num_value = '0;
            num_digits = 0;
            num_too_long = 1'b0;
            add_digit(c);
            scan_mode = SCAN_NUM;
        end else if (c == CH_COLON) begin
            scan_mode = SCAN_COLON;
        end else if (c == CH_LESS) begin
            scan_mode = SCAN_LESS;
        end else if (c == CH_GREATER) begin
            scan_mode = SCAN_GREATER;
        end else begin
            add_token(punct_symbol(c), '0, '0, '0, '0);
        end
    endtask

    // one accepted word: works out its tokens and queues them as expected
    task automatic scan_word(input logic action, input logic [7:0] c);
        logic [SYM_W-1:0] pair_sym;
        bit               absorbed;
        run_toks.delete();
        pair_sym = SY_NUL;
        absorbed = 1'b0;
        if (action == ACT_END) begin
            flush_pending();
        end else if (c != CH_TAB) begin
            case (scan_mode)
                SCAN_NAME: begin
                    if (is_upper(c) || is_digit(c)) begin
                        if (name_len < NAME_KEEP) begin
                            name_chars[name_len] = c;
                            name_len++;
                        end
                        absorbed = 1'b1;
                    end
                end
                SCAN_NUM: begin
                    if (is_digit(c)) begin
                        add_digit(c);
                        absorbed = 1'b1;
                    end
                end
                SCAN_COLON: if (c == CH_EQUAL) pair_sym = SY_BECOMES;
                SCAN_LESS: begin
                    if (c == CH_EQUAL) pair_sym = SY_LEQ;
                    else if (c == CH_GREATER) pair_sym = SY_NEQ;
                end
                SCAN_GREATER: if (c == CH_EQUAL) pair_sym = SY_GEQ;
                default: ;
            endcase
            if (pair_sym != SY_NUL) begin
                scan_mode = SCAN_IDLE;
                add_token(pair_sym, '0, '0, '0, '0);
            end else if (!absorbed) begin
                // the pending token goes out ahead of whatever this char makes
                flush_pending();
                start_token(c);
            end
        end
        if (run_toks.size() > 0) run_toks[run_toks.size()-1].last_of_run = 1'b1;
        foreach (run_toks[i]) tok_expected.push_back(run_toks[i]);
    endtask

    task automatic check_field(input string fname, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want_v, got_v);
            err_count++;
        end
    endtask

    task automatic queue_word(input logic action, input logic [7:0] c);
        src_word_t w;
        w.action = action;
        w.ch     = c;
        w.hold   = ($urandom_range(49) == 0);
        src_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_char(input logic [7:0] c);
        queue_word(ACT_CHAR, c);
    endtask

    task automatic queue_end();
        queue_word(ACT_END, 8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] random_name_char();
        if ($urandom_range(2) == 0) return 8'($urandom_range(CH_ZERO, CH_NINE));
        return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
    endfunction

    // mostly well-formed program text, with noise bytes and stray end words
    task automatic queue_random_text(input int target);
        int stop_at;
        int kind;
        int len;
        int k;
        bit nines;
        stop_at = words_queued + target;
        while (words_queued < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 22) begin
                if ($urandom_range(1) == 1) begin
                    k = $urandom_range(KW_COUNT-1);
                    for (int i = 0; i < KW_LEN[k]; i++) queue_char(KW_TEXT[k][NAME_W-1-8*i -: 8]);
                    if ($urandom_range(3) == 0) queue_char(random_name_char());
                end else begin
                    len = ($urandom_range(4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
                    queue_char(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
                    for (int i = 1; i < len; i++) begin
                        if ($urandom_range(19) == 0) queue_char(CH_TAB);
                        queue_char(random_name_char());
                    end
                end
            end else if (kind < 38) begin
                nines = ($urandom_range(4) == 0);
                len = ($urandom_range(3) == 0) ? $urandom_range(13, 17) : $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    queue_char(nines ? CH_NINE : 8'($urandom_range(CH_ZERO, CH_NINE)));
                end
            end else if (kind < 52) begin
                case ($urandom_range(6))
                    0: begin queue_char(CH_COLON); queue_char(CH_EQUAL); end
                    1: begin queue_char(CH_LESS); queue_char(CH_EQUAL); end
                    2: begin queue_char(CH_LESS); queue_char(CH_GREATER); end
                    3: begin queue_char(CH_GREATER); queue_char(CH_EQUAL); end
                    4: queue_char(CH_COLON);
                    5: queue_char(CH_LESS);
                    default: queue_char(CH_GREATER);
                endcase
            end else if (kind < 66) begin
                queue_char(PUNCT_CHARS[$urandom_range(12)]);
            end else if (kind < 76) begin
                queue_char(SEP_CHARS[$urandom_range(3)]);
            end else if (kind < 81) begin
                queue_end();
            end else if (kind < 92) begin
                queue_char(8'($urandom_range(255)));
            end else if ($urandom_range(1) == 1) begin
                queue_char(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
            end else begin
                queue_char(8'($urandom_range(128, 255)));
            end
            // names and numbers usually end at a blank, sometimes run into the next token
            if (kind < 38 && $urandom_range(2) != 0) queue_char(CH_SPACE);
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (src_words.size() != 0 || s_tvalid || tok_expected.size() != 0);
    endtask

    // driver: new word on the falling edge once the last one was taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (src_words.size() != 0 && !(src_words[0].hold && tok_expected.size() != 0)
                    && $urandom_range(99) >= send_idle) begin
                s_tvalid <= 1'b1;
                s_tuser  <= src_words[0].action;
                s_tdata  <= src_words[0].ch;
                void'(src_words.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // monitor: predict on accepted input words, check accepted token words
    always @(posedge aclk) begin
        tok_t want;
        if (!aresetn) begin
            word_taken  <= 1'b0;
            idle_cycles <= 0;
        end else begin
            word_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) scan_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (tok_expected.size() == 0) begin
                    $display("%0t: unexpected token word, expected none, actual tdata %h tlast %b",
                             $time, m_tdata, m_tlast);
                    err_count++;
                end else begin
                    want = tok_expected.pop_front();
                    check_field("symbol", want.symbol, m_tdata[5:0]);
                    check_field("number_value", want.number_value, m_tdata[52:6]);
                    check_field("ident_head", want.ident_head, m_tdata[116:53]);
                    check_field("ident_tail", want.ident_tail, m_tdata[132:117]);
                    check_field("ident_length", want.ident_length, m_tdata[136:133]);
                    check_field("tdata padding", '0, m_tdata[143:137]);
                    check_field("last_of_run", want.last_of_run, m_tlast);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 37;
        recv_idle = 79;
        // end with nothing pending, then the bytes at both ends of the range and lowercase
        queue_end();
        queue_char(8'h00);
        queue_char(8'hFF);
        queue_char(CH_LOWER_A);
        queue_char("I");
        queue_char("F");
        queue_char(CH_SPACE);
        // tab inside a name and inside ':='
        queue_char("A");
        queue_char(CH_TAB);
        queue_char("9");
        queue_char(CH_COLON);
        queue_char(CH_TAB);
        queue_char(CH_EQUAL);
        // pairs, then lone '<' and '>' followed by tokens of their own
        queue_char(CH_LESS);
        queue_char(CH_GREATER);
        queue_char(CH_GREATER);
        queue_char(CH_EQUAL);
        queue_char(CH_LESS);
        queue_char(CH_LPAREN);
        queue_char(CH_GREATER);
        queue_char("5");
        queue_char("0");
        queue_char(CH_PERIOD);
        queue_end();
        queue_random_text(160);
        wait_drained();

        @(posedge aclk);
        send_idle = 79;
        recv_idle = 37;
        queue_random_text(170);
        wait_drained();

        @(posedge aclk);
        send_idle = 0;
        recv_idle = 0;
        queue_random_text(170);
        queue_end();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0 && tok_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- pl0_token_scanner.f -----
hdl/pl0ts_pkg.sv
hdl/pl0ts_kw_match.sv
hdl/pl0ts_tok_queue.sv
hdl/pl0_token_scanner.sv
test/pl0_token_scanner_tb.sv
